[hdl/gradient_non_maximum_suppression_defines.svh]
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression_defines.svh
// Assertion macros shared by the edge thinning block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NON_MAXIMUM_SUPPRESSION_DEFINES_SVH
`define GRADIENT_NON_MAXIMUM_SUPPRESSION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// expression must hold at every clock edge out of reset
`define GNMS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("gnms check failed in %m");
// consequent must hold in the same cycle as the antecedent
`define GNMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gnms check failed in %m");
`else
`define GNMS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define GNMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/gnms_pkg.sv]
// ----------------------------------------------------------------------------
// gnms_pkg
// Types and constants of the gradient non-maximum suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnms_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = 10;
	localparam int ROW_W       = 12;
	localparam int FW_W        = 11;
	localparam int MAG_W       = 16;
	localparam int DIM_MIN     = 3;
	localparam int FW_RESET    = 640;
	localparam int FH_RESET    = 480;

	// output queue and the stages that feed it
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_W    = 3;
	localparam int OQ_CNT_W    = 4;
	localparam int PIPE_STAGES = 4;
	localparam int OQ_ROOM     = OQ_DEPTH - PIPE_STAGES - 1;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef logic [COL_W-1:0]    col_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [ROW_W:0]      row_ext_t;
	typedef logic [FW_W-1:0]     width_t;
	typedef logic [MAG_W-1:0]    mag_t;
	typedef logic [OQ_CNT_W-1:0] oq_cnt_t;
	typedef logic [OQ_PTR_W-1:0] oq_ptr_t;

	// 3x3 magnitude window: [row 0 = oldest line][column 0 = oldest pixel]
	typedef logic [2:0][2:0][MAG_W-1:0] gnms_win_t;

	typedef struct packed {
		logic emit;
		row_t row;
		col_t col;
		logic last;
	} gnms_tag_t;

	// accepted pixel with its resolved position
	typedef struct packed {
		logic      valid;
		col_t      addr;
		mag_t      gx;
		mag_t      gy;
		mag_t      mag;
		gnms_tag_t tag;
	} gnms_pix_t;

	// neighborhood of one interior centre pixel
	typedef struct packed {
		logic      valid;
		gnms_win_t win;
		mag_t      gx;
		mag_t      gy;
		gnms_tag_t tag;
	} gnms_nbr_t;

	typedef struct packed {
		logic is_edge;
		row_t row;
		col_t col;
		logic last;
	} gnms_res_t;

endpackage

`default_nettype wire

[hdl/gradient_non_maximum_suppression.sv]
// ----------------------------------------------------------------------------
// gradient_non_maximum_suppression
// Canny non-maximum suppression with interpolation over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage: feed gradient pixels (gx, gy, magnitude) on the s_ stream in raster
// order, tuser high on the first pixel of a frame. One result per interior
// pixel leaves on the m_ stream; border rows and columns produce nothing.
// The decision for a centre pixel is made when the pixel one row below and
// one column right of it arrives, so results trail the input by a line.
// Throughput is one pixel per clock while s_tready is high: the two line
// memories (one packed pair of magnitude lines, one gradient line) are read at
// the column address on acceptance and written back the next cycle, with the
// written data forwarded when the same column is read again in the following cycle.
// From acceptance to m_tvalid a pixel passes the line read, then window, octant
// select, multipliers, and compare into an 8-entry output queue.
// When the receiver stalls, the queue fills and s_tready drops once only the
// in-flight pipeline fits; no result is lost or repeated.
// Reset clears position, window and queue and sets the frame to 640 x 480; line
// memory contents are not cleared. frame_width and frame_height are written on the
// cfg_ channel (index 0 and 1) while the stream is idle: the user's duty, unenforced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gradient_non_maximum_suppression_defines.svh"

module gradient_non_maximum_suppression (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // grad_x [15:0], grad_y [31:16], magnitude [47:32]
	input  wire logic        s_tuser,   // start_frame [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // is_edge [0], out_row [12:1], out_col [22:13]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	gnms_pkg::width_t  frame_width_q, w_eff;
	gnms_pkg::row_t    frame_height_q, h_eff;
	gnms_pkg::col_t    col_q, c, col_nx;
	gnms_pkg::row_t    row_q, r, row_nx;
	gnms_pkg::width_t  col_a, col_b, col_n;
	gnms_pkg::row_ext_t row_a, row_b, row_c, row_n;
	logic              accept;

	gnms_pkg::gnms_pix_t pix;
	gnms_pkg::gnms_nbr_t nbr;
	gnms_pkg::gnms_res_t res, head;
	gnms_pkg::oq_cnt_t   oq_count;
	logic                push, not_empty;

	assign cfg_ready = 1'b1;
	assign s_tready  = oq_count <= gnms_pkg::oq_cnt_t'(gnms_pkg::OQ_ROOM);
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		if (frame_width_q < gnms_pkg::width_t'(gnms_pkg::DIM_MIN)) begin
			w_eff = gnms_pkg::width_t'(gnms_pkg::DIM_MIN);
		end else if (frame_width_q > gnms_pkg::width_t'(gnms_pkg::MAX_WIDTH)) begin
			w_eff = gnms_pkg::width_t'(gnms_pkg::MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < gnms_pkg::row_t'(gnms_pkg::DIM_MIN)) begin
			h_eff = gnms_pkg::row_t'(gnms_pkg::DIM_MIN);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// resolve this pixel's position, then the position of the next one
	always_comb begin
		col_a = s_tuser ? '0 : {1'b0, col_q};
		row_a = s_tuser ? '0 : {1'b0, row_q};
		if (col_a >= w_eff) begin
			col_b = '0;
			row_b = row_a + gnms_pkg::row_ext_t'(1);
		end else begin
			col_b = col_a;
			row_b = row_a;
		end
		row_c = (row_b >= {1'b0, h_eff}) ? '0 : row_b;
		c     = col_b[gnms_pkg::COL_W-1:0];
		r     = row_c[gnms_pkg::ROW_W-1:0];

		col_n = {1'b0, c} + gnms_pkg::width_t'(1);
		row_n = {1'b0, r} + gnms_pkg::row_ext_t'(1);
		if (col_n >= w_eff) begin
			col_nx = '0;
			row_nx = (row_n >= {1'b0, h_eff}) ? '0 : row_n[gnms_pkg::ROW_W-1:0];
		end else begin
			col_nx = col_n[gnms_pkg::COL_W-1:0];
			row_nx = r;
		end
	end

	always_comb begin
		pix.valid    = accept;
		pix.addr     = c;
		pix.gx       = s_tdata[15:0];
		pix.gy       = s_tdata[31:16];
		pix.mag      = s_tdata[47:32];
		pix.tag.emit = (r >= gnms_pkg::row_t'(2)) && (c >= gnms_pkg::col_t'(2));
		pix.tag.row  = r - gnms_pkg::row_t'(1);
		pix.tag.col  = c - gnms_pkg::col_t'(1);
		pix.tag.last = (r == h_eff - gnms_pkg::row_t'(1)) &&
			({1'b0, c} == w_eff - gnms_pkg::width_t'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gnms_pkg::width_t'(gnms_pkg::FW_RESET);
			frame_height_q <= gnms_pkg::row_t'(gnms_pkg::FH_RESET);
			col_q          <= '0;
			row_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gnms_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[gnms_pkg::FW_W-1:0];
					gnms_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				col_q <= col_nx;
				row_q <= row_nx;
			end
		end
	end

	gnms_lines u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.nbr    (nbr)
	);

	gnms_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.nbr    (nbr),
		.push   (push),
		.res    (res)
	);

	gnms_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.pop       (m_tready),
		.not_empty (not_empty),
		.head      (head),
		.count     (oq_count)
	);

	assign m_tvalid = not_empty;
	assign m_tdata  = {1'b0, head.col, head.row, head.is_edge};
	assign m_tlast  = head.last;

	`GNMS_ASSERT_IMPLY(a_oq_room, clk, arst_n, push, oq_count < gnms_pkg::oq_cnt_t'(gnms_pkg::OQ_DEPTH))
	`GNMS_ASSERT_IMPLY(a_interior, clk, arst_n, push, (res.row != '0) && (res.col != '0))
	`GNMS_ASSERT_IMPLY(a_col_in_row, clk, arst_n, accept, ({1'b0, c} < w_eff))

endmodule

`default_nettype wire

[hdl/gnms_lines.sv]
// ----------------------------------------------------------------------------
// gnms_lines
// Line stores, forwarding and 3x3 window for the suppression pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_lines (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gnms_pkg::gnms_pix_t   pix,
	output gnms_pkg::gnms_nbr_t        nbr
);

	// each entry: [15:0] line two rows up, [31:16] line one row up
	logic [31:0] mag_mem  [gnms_pkg::MAX_WIDTH];
	// each entry: [15:0] gx, [31:16] gy of the row above
	logic [31:0] grad_mem [gnms_pkg::MAX_WIDTH];

	logic [31:0] mag_rd_q, grad_rd_q;
	logic [31:0] mag_wr_q, grad_wr_q;
	logic [31:0] mag_rd, grad_rd, mag_wr, grad_wr;

	logic                valid_s1, fwd_s1;
	gnms_pkg::col_t      addr_s1;
	gnms_pkg::mag_t      mag_s1;
	logic [31:0]         grad_s1;
	gnms_pkg::gnms_tag_t tag_s1;

	gnms_pkg::gnms_win_t window_q, win_next;
	logic [31:0]         grad_hold_q;

	logic                valid_s2;
	gnms_pkg::gnms_win_t win_s2;
	logic [31:0]         grad_s2;
	gnms_pkg::gnms_tag_t tag_s2;

	always_ff @(posedge clk) begin
		if (pix.valid) begin
			mag_rd_q  <= mag_mem[pix.addr];
			grad_rd_q <= grad_mem[pix.addr];
		end
		if (valid_s1) begin
			mag_mem[addr_s1]  <= mag_wr;
			grad_mem[addr_s1] <= grad_wr;
		end
	end

	// a write at the same edge as a read of the same entry is not yet seen: forward it
	assign mag_rd  = fwd_s1 ? mag_wr_q  : mag_rd_q;
	assign grad_rd = fwd_s1 ? grad_wr_q : grad_rd_q;
	assign mag_wr  = {mag_s1, mag_rd[31:16]};
	assign grad_wr = grad_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_next[k][0] = window_q[k][1];
			win_next[k][1] = window_q[k][2];
		end
		win_next[0][2] = mag_rd[15:0];
		win_next[1][2] = mag_rd[31:16];
		win_next[2][2] = mag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			valid_s2    <= 1'b0;
			window_q    <= '0;
			grad_hold_q <= '0;
		end else begin
			valid_s1 <= pix.valid;
			fwd_s1   <= pix.valid && valid_s1 && (pix.addr == addr_s1);
			valid_s2 <= valid_s1 && tag_s1.emit;
			if (valid_s1) begin
				window_q    <= win_next;
				grad_hold_q <= grad_rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid) begin
			addr_s1 <= pix.addr;
			mag_s1  <= pix.mag;
			grad_s1 <= {pix.gy, pix.gx};
			tag_s1  <= pix.tag;
		end
		if (valid_s1) begin
			mag_wr_q  <= mag_wr;
			grad_wr_q <= grad_wr;
			win_s2    <= win_next;
			grad_s2   <= grad_hold_q;
			tag_s2    <= tag_s1;
		end
	end

	always_comb begin
		nbr.valid = valid_s2;
		nbr.win   = win_s2;
		nbr.gx    = grad_s2[15:0];
		nbr.gy    = grad_s2[31:16];
		nbr.tag   = tag_s2;
	end

endmodule

`default_nettype wire

[hdl/gnms_decide.sv]
// ----------------------------------------------------------------------------
// gnms_decide
// Octant selection, cross-multiplied interpolation and local maximum test.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_decide (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gnms_pkg::gnms_nbr_t   nbr,
	output logic                       push,
	output gnms_pkg::gnms_res_t        res
);

	gnms_pkg::mag_t ax, ay, n, d, a1, b1, a2, b2;
	logic           ge, le;

	logic                valid_s3;
	gnms_pkg::mag_t      ctr_s3, a1_s3, b1_s3, a2_s3, b2_s3, n_s3, dn_s3, d_s3;
	gnms_pkg::gnms_tag_t tag_s3;

	logic [31:0] p_md, p_a1, p_b1, p_a2, p_b2;

	logic                valid_s4;
	logic [31:0]         md_s4, a1_s4, b1_s4, a2_s4, b2_s4;
	gnms_pkg::gnms_tag_t tag_s4;

	logic [32:0] sum1, sum2;
	logic        beat1, beat2;

	assign ax = nbr.gx[15] ? (~nbr.gx + 16'd1) : nbr.gx;
	assign ay = nbr.gy[15] ? (~nbr.gy + 16'd1) : nbr.gy;
	assign ge = ax >= ay;
	assign le = ay >= ax;
	assign n  = ge ? ay : ax;
	assign d  = ge ? ax : ay;

	// pick the neighbor pairs on both sides along the gradient
	always_comb begin
		case ({nbr.gx[15], nbr.gy[15]})
			2'b00: begin
				if (ge) begin
					a1 = nbr.win[1][2]; b1 = nbr.win[2][2]; a2 = nbr.win[1][0]; b2 = nbr.win[0][0];
				end else begin
					a1 = nbr.win[2][1]; b1 = nbr.win[2][2]; a2 = nbr.win[0][1]; b2 = nbr.win[0][0];
				end
			end
			2'b01: begin
				if (ge) begin
					a1 = nbr.win[1][2]; b1 = nbr.win[0][2]; a2 = nbr.win[1][0]; b2 = nbr.win[2][0];
				end else begin
					a1 = nbr.win[0][1]; b1 = nbr.win[0][2]; a2 = nbr.win[2][1]; b2 = nbr.win[2][0];
				end
			end
			2'b10: begin
				if (le) begin
					a1 = nbr.win[2][1]; b1 = nbr.win[2][0]; a2 = nbr.win[0][1]; b2 = nbr.win[0][2];
				end else begin
					a1 = nbr.win[1][0]; b1 = nbr.win[2][0]; a2 = nbr.win[1][2]; b2 = nbr.win[0][2];
				end
			end
			2'b11: begin
				if (ge) begin
					a1 = nbr.win[1][0]; b1 = nbr.win[0][0]; a2 = nbr.win[1][2]; b2 = nbr.win[2][2];
				end else begin
					a1 = nbr.win[0][1]; b1 = nbr.win[0][0]; a2 = nbr.win[2][1]; b2 = nbr.win[2][2];
				end
			end
			default: begin
				a1 = '0; b1 = '0; a2 = '0; b2 = '0;
			end
		endcase
	end

	assign p_md = ctr_s3 * d_s3;
	assign p_a1 = a1_s3 * dn_s3;
	assign p_b1 = b1_s3 * n_s3;
	assign p_a2 = a2_s3 * dn_s3;
	assign p_b2 = b2_s3 * n_s3;

	// centre*D > A*(D-n) + B*n; a zero gradient never passes
	assign sum1  = {1'b0, a1_s4} + {1'b0, b1_s4};
	assign sum2  = {1'b0, a2_s4} + {1'b0, b2_s4};
	assign beat1 = {1'b0, md_s4} > sum1;
	assign beat2 = {1'b0, md_s4} > sum2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= nbr.valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (nbr.valid) begin
			ctr_s3 <= nbr.win[1][1];
			a1_s3  <= a1;
			b1_s3  <= b1;
			a2_s3  <= a2;
			b2_s3  <= b2;
			n_s3   <= n;
			d_s3   <= d;
			dn_s3  <= d - n;
			tag_s3 <= nbr.tag;
		end
		if (valid_s3) begin
			md_s4  <= p_md;
			a1_s4  <= p_a1;
			b1_s4  <= p_b1;
			a2_s4  <= p_a2;
			b2_s4  <= p_b2;
			tag_s4 <= tag_s3;
		end
	end

	assign push = valid_s4;

	always_comb begin
		res.is_edge = beat1 && beat2;
		res.row     = tag_s4.row;
		res.col     = tag_s4.col;
		res.last    = tag_s4.last;
	end

endmodule

`default_nettype wire

[hdl/gnms_oq.sv]
// ----------------------------------------------------------------------------
// gnms_oq
// Output queue that decouples the fixed-latency pipeline from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module gnms_oq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire gnms_pkg::gnms_res_t   push_res,
	input  wire logic                  pop,
	output logic                       not_empty,
	output gnms_pkg::gnms_res_t        head,
	output gnms_pkg::oq_cnt_t          count
);

	gnms_pkg::gnms_res_t entry_q [gnms_pkg::OQ_DEPTH];
	gnms_pkg::oq_ptr_t   wr_ptr_q, rd_ptr_q;
	gnms_pkg::oq_cnt_t   count_q;
	logic                do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gnms_pkg::oq_ptr_t'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + gnms_pkg::oq_ptr_t'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + gnms_pkg::oq_cnt_t'(1);
				2'b01:   count_q <= count_q - gnms_pkg::oq_cnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire
